/* rtl/iebm_pkg.sv */
// Shared types and constants for the I2C EEPROM byte master.
`timescale 1ns / 1ps

package iebm_pkg;

  localparam int LATCH_DEPTH = 5;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] ACK_WAIT_RESET = 8'd50;

  typedef struct packed {
    logic       start;
    logic       rd;
    logic [7:0] dev_wr;
    logic [7:0] dev_rd;
    logic [7:0] addr_hi;
    logic [7:0] addr_lo;
    logic [7:0] wdata;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [2:0] pad;
    logic       nack_seen;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_level;
  } res_t;

endpackage

/* rtl/iebm_front.sv */
// Input side: decodes each beat into a bus item and queues it for the sequencer.
`timescale 1ns / 1ps

module iebm_front
  import iebm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // device_write_byte, device_read_byte, mem_addr_high, mem_addr_low, write_data, sda_in, zero pad
  input  logic [IN_DATA_W-1:0] s_tdata,
  // opcode
  input  logic [1:0]           s_tuser,
  output logic                 head_valid,
  output item_t                head,
  input  logic                 pop
);

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      item;
  logic       push;

  always_comb begin
    item.start   = (s_tuser == OP_WRITE) || (s_tuser == OP_READ);
    item.rd      = (s_tuser == OP_READ);
    item.dev_wr  = s_tdata[7:0];
    item.dev_rd  = s_tdata[15:8];
    item.addr_hi = s_tdata[23:16];
    item.addr_lo = s_tdata[31:24];
    item.wdata   = s_tdata[39:32];
    item.sda_in  = s_tdata[40];
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/iebm_back.sv */
// Bus phase sequencer: steps one phase per queued item and registers the result beat.
`timescale 1ns / 1ps

module iebm_back
  import iebm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  item_t                 head,
  output logic                  pop,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // scl_level, sda_release, busy_res, done_res, read_data, nack_seen, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_ST_A = 5'd1;
  localparam logic [4:0] PH_ST_B = 5'd2;
  localparam logic [4:0] PH_ST_C = 5'd3;
  localparam logic [4:0] PH_ST_D = 5'd4;
  localparam logic [4:0] PH_TX_L = 5'd5;
  localparam logic [4:0] PH_TX_H = 5'd6;
  localparam logic [4:0] PH_TX_E = 5'd7;
  localparam logic [4:0] PH_AK_R = 5'd8;
  localparam logic [4:0] PH_AK_H = 5'd9;
  localparam logic [4:0] PH_AK_E = 5'd10;
  localparam logic [4:0] PH_RX_L = 5'd11;
  localparam logic [4:0] PH_RX_H = 5'd12;
  localparam logic [4:0] PH_MN_L = 5'd13;
  localparam logic [4:0] PH_MN_H = 5'd14;
  localparam logic [4:0] PH_MN_E = 5'd15;
  localparam logic [4:0] PH_SP_A = 5'd16;
  localparam logic [4:0] PH_SP_B = 5'd17;
  localparam logic [4:0] PH_SP_C = 5'd18;

  logic [4:0] phase, phase_next, phase_cur;
  logic [3:0] bit_count, bit_count_next;
  logic [2:0] byte_index, byte_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] read_byte, read_byte_next;
  logic [7:0] ack_cnt, ack_cnt_next;
  logic       nack_flag, nack_flag_next;
  logic       is_read, is_read_next;
  logic [7:0] latched [LATCH_DEPTH];
  logic [7:0] latched_next [LATCH_DEPTH];
  logic [7:0] ack_limit;
  logic [7:0] cur_byte;
  logic       txbit;
  res_t       res;
  res_t       out_reg;

  assign cfg_ready = 1'b1;
  assign pop       = head_valid && (!m_tvalid || m_tready);
  assign m_tdata   = out_reg;
  assign txbit     = shift_reg[7];

  always_comb begin
    unique case (byte_index_next)
      3'd0:    cur_byte = latched_next[0];
      3'd1:    cur_byte = latched_next[1];
      3'd2:    cur_byte = latched_next[2];
      3'd3:    cur_byte = latched_next[3];
      3'd4:    cur_byte = latched_next[4];
      default: cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    read_byte_next  = read_byte;
    ack_cnt_next    = ack_cnt;
    nack_flag_next  = nack_flag;
    is_read_next    = is_read;
    latched_next    = latched;
    byte_index_next = byte_index;
    phase_cur       = phase;
    if ((phase == PH_IDLE) && head.start) begin
      latched_next[0] = head.dev_wr;
      latched_next[1] = head.addr_hi;
      latched_next[2] = head.addr_lo;
      latched_next[3] = head.wdata;
      latched_next[4] = head.dev_rd;
      is_read_next    = head.rd;
      nack_flag_next  = 1'b0;
      byte_index_next = 3'd0;
      bit_count_next  = 4'd0;
      phase_cur       = PH_ST_A;
    end
    res             = '0;
    res.scl_level   = 1'b1;
    res.sda_release = 1'b1;
    res.busy_res    = 1'b1;
    phase_next      = phase_cur;
    unique case (phase_cur)
      PH_ST_A: begin
        res.scl_level = 1'b0;
        phase_next    = PH_ST_B;
      end
      PH_ST_B: phase_next = PH_ST_C;
      PH_ST_C: begin
        res.sda_release = 1'b0;
        phase_next      = PH_ST_D;
      end
      PH_ST_D: begin
        res.scl_level   = 1'b0;
        res.sda_release = 1'b0;
        shift_reg_next  = cur_byte;
        bit_count_next  = 4'd0;
        phase_next      = PH_TX_L;
      end
      PH_TX_L: begin
        res.scl_level   = 1'b0;
        res.sda_release = txbit;
        phase_next      = PH_TX_H;
      end
      PH_TX_H: begin
        res.sda_release = txbit;
        phase_next      = PH_TX_E;
      end
      PH_TX_E: begin
        res.scl_level   = 1'b0;
        res.sda_release = txbit;
        shift_reg_next  = {shift_reg[6:0], 1'b0};
        bit_count_next  = bit_count + 4'd1;
        phase_next      = (bit_count_next >= 4'd8) ? PH_AK_R : PH_TX_L;
      end
      PH_AK_R: begin
        res.scl_level = 1'b0;
        ack_cnt_next  = 8'd0;
        phase_next    = PH_AK_H;
      end
      PH_AK_H: begin
        if (!head.sda_in) begin
          phase_next = PH_AK_E;
        end else if (ack_cnt >= ack_limit) begin
          nack_flag_next = 1'b1;
          phase_next     = PH_AK_E;
        end else begin
          ack_cnt_next = ack_cnt + 8'd1;
        end
      end
      PH_AK_E: begin
        res.scl_level  = 1'b0;
        bit_count_next = 4'd0;
        if (!is_read) begin
          if (byte_index >= 3'd3) begin
            phase_next = PH_SP_A;
          end else begin
            byte_index_next = byte_index + 3'd1;
            shift_reg_next  = cur_byte;
            phase_next      = PH_TX_L;
          end
        end else if (byte_index >= 3'd4) begin
          shift_reg_next = 8'd0;
          phase_next     = PH_RX_L;
        end else if (byte_index == 3'd2) begin
          byte_index_next = 3'd4;
          phase_next      = PH_ST_A;
        end else begin
          byte_index_next = byte_index + 3'd1;
          shift_reg_next  = cur_byte;
          phase_next      = PH_TX_L;
        end
      end
      PH_RX_L: begin
        res.scl_level = 1'b0;
        phase_next    = PH_RX_H;
      end
      PH_RX_H: begin
        shift_reg_next = {shift_reg[6:0], head.sda_in};
        bit_count_next = bit_count + 4'd1;
        if (bit_count_next >= 4'd8) begin
          read_byte_next = shift_reg_next;
          phase_next     = PH_MN_L;
        end else begin
          phase_next = PH_RX_L;
        end
      end
      PH_MN_L: begin
        res.scl_level = 1'b0;
        phase_next    = PH_MN_H;
      end
      PH_MN_H: phase_next = PH_MN_E;
      PH_MN_E: begin
        res.scl_level = 1'b0;
        phase_next    = PH_SP_A;
      end
      PH_SP_A: begin
        res.scl_level   = 1'b0;
        res.sda_release = 1'b0;
        phase_next      = PH_SP_B;
      end
      PH_SP_B: begin
        res.sda_release = 1'b0;
        phase_next      = PH_SP_C;
      end
      PH_SP_C: begin
        res.busy_res = 1'b0;
        res.done_res = 1'b1;
        phase_next   = PH_IDLE;
      end
      default: begin
        res.busy_res = 1'b0;
        phase_next   = PH_IDLE;
      end
    endcase
    res.read_data = read_byte_next;
    res.nack_seen = nack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_reg <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_limit  <= ACK_WAIT_RESET;
      m_tvalid   <= 1'b0;
      phase      <= PH_IDLE;
      bit_count  <= 4'd0;
      byte_index <= 3'd0;
      shift_reg  <= 8'd0;
      read_byte  <= 8'd0;
      ack_cnt    <= 8'd0;
      nack_flag  <= 1'b0;
      is_read    <= 1'b0;
      for (int i = 0; i < LATCH_DEPTH; i++) begin
        latched[i] <= 8'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        ack_limit <= cfg_data;
      end
      if (pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        phase      <= phase_next;
        bit_count  <= bit_count_next;
        byte_index <= byte_index_next;
        shift_reg  <= shift_reg_next;
        read_byte  <= read_byte_next;
        ack_cnt    <= ack_cnt_next;
        nack_flag  <= nack_flag_next;
        is_read    <= is_read_next;
        latched    <= latched_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_fills_out: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid)
    else $error("result beat lost after a step");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'd8)
    else $error("bit count past one byte");

  a_byte_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= 3'd4)
    else $error("byte index past latched bytes");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_reg.done_res) |-> !out_reg.busy_res)
    else $error("done beat still reports busy");
`endif

endmodule

/* rtl/i2c_eeprom_byte_master.sv */
// I2C EEPROM byte master, top level: input queue front end and phase sequencer.
`timescale 1ns / 1ps

// Each input beat is one bus tick and yields exactly one result beat giving the SCL
// and SDA levels for that tick, busy, done, the last read byte and the nack flag. A
// start write or start read opcode begins a transaction only when the sequencer is
// idle. The block takes one beat per clock cycle while the output is not stalled; a
// result passes through the two-entry input queue and then the sequencer's output
// register. The user must write the ack wait limit through the cfg channel only while
// no transaction is running; the block itself does not enforce this.

module i2c_eeprom_byte_master
  import iebm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // device_write_byte, device_read_byte, mem_addr_high, mem_addr_low, write_data, sda_in, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // scl_level, sda_release, busy_res, done_res, read_data, nack_seen, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);

  logic  head_valid;
  item_t head;
  logic  pop;

  iebm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  iebm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
